// ===== rtl/ahlg_pkg.sv =====
// Shared constants, template tables and types for the arrowhead line generator.
`timescale 1ns / 1ps
package ahlg_pkg;

  localparam int NUM_BARBS = 12;
  localparam int BARB_IDX_W = 4;
  localparam int COLOR_W = 9;
  localparam int HANDLE_W = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COLOR = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HANDLE = 4'd1;

  localparam logic [COLOR_W-1:0] COLOR_RESET = 9'd7;

  // 0.9659/20 and 0.2588/20 in Q0.32, cos(30) in Q0.16
  localparam logic [31:0] K_LONG_Q32 = 32'd207425446;
  localparam logic [31:0] K_SHORT_Q32 = 32'd55576877;
  localparam logic [31:0] K_COS30_Q16 = 32'd56754;

  // Template ring point selector: zero, b, c (b*cos30) or h (b/2)
  typedef logic [1:0] tsel_t;
  localparam tsel_t SEL_ZERO = 2'd0;
  localparam tsel_t SEL_B = 2'd1;
  localparam tsel_t SEL_C = 2'd2;
  localparam tsel_t SEL_H = 2'd3;

  typedef struct packed {
    logic  neg;
    tsel_t sel;
  } tcode_t;

  localparam tcode_t TMPL_Y [NUM_BARBS] = '{
    {1'b0, SEL_B}, {1'b1, SEL_B}, {1'b0, SEL_ZERO}, {1'b0, SEL_ZERO},
    {1'b0, SEL_C}, {1'b1, SEL_C}, {1'b0, SEL_H}, {1'b1, SEL_H},
    {1'b0, SEL_C}, {1'b1, SEL_C}, {1'b0, SEL_H}, {1'b1, SEL_H}
  };

  localparam tcode_t TMPL_Z [NUM_BARBS] = '{
    {1'b0, SEL_ZERO}, {1'b0, SEL_ZERO}, {1'b0, SEL_B}, {1'b1, SEL_B},
    {1'b0, SEL_H}, {1'b0, SEL_H}, {1'b0, SEL_C}, {1'b0, SEL_C},
    {1'b1, SEL_H}, {1'b1, SEL_H}, {1'b1, SEL_C}, {1'b1, SEL_C}
  };

  // Request to the root / divide unit
  typedef struct packed {
    logic start;
    logic is_root;
  } ru_req_t;

endpackage

// ===== rtl/ahlg_in_if.sv =====
// Input channel: arrow tip and direction word.
`timescale 1ns / 1ps
interface ahlg_in_if #(parameter int CW = 32);
  logic valid;
  logic ready;
  logic signed [CW-1:0] mid_x;
  logic signed [CW-1:0] mid_y;
  logic signed [CW-1:0] mid_z;
  logic signed [CW-1:0] delta_x;
  logic signed [CW-1:0] delta_y;
  logic signed [CW-1:0] delta_z;

  modport source (output valid, mid_x, mid_y, mid_z, delta_x, delta_y, delta_z,
                  input ready);
  modport sink (input valid, mid_x, mid_y, mid_z, delta_x, delta_y, delta_z,
                output ready);
endinterface

// ===== rtl/ahlg_out_if.sv =====
// Result channel: one line word per barb.
`timescale 1ns / 1ps
interface ahlg_out_if #(parameter int CW = 32);
  import ahlg_pkg::*;
  logic valid;
  logic ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] start_z;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] end_z;
  logic [HANDLE_W-1:0] object_handle;
  logic [COLOR_W-1:0] line_color;
  logic last_line;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  object_handle, line_color, last_line, input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                object_handle, line_color, last_line, output ready);
endinterface

// ===== rtl/ahlg_cfg_if.sv =====
// Configuration write channel.
`timescale 1ns / 1ps
interface ahlg_cfg_if;
  import ahlg_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/ahlg_mul.sv =====
// Shared magnitude multiplier, eight multiplier bits per cycle, with preset accumulator.
`timescale 1ns / 1ps
module ahlg_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  input  logic [AW+BW-1:0] bias,
  output logic             done,
  output logic [AW+BW-1:0] prod
);
  localparam int PW = AW + BW;

  logic          busy_r;
  logic [PW-1:0] acc_r;
  logic [PW-1:0] ash_r;
  logic [BW-1:0] b_r;
  logic [PW+7:0] pp;

  assign pp = ash_r * b_r[7:0];
  assign done = busy_r && (b_r == '0);
  assign prod = acc_r;

  // busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  // shift-add datapath, stops once the multiplier runs out of set bits
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= bias;
      ash_r <= PW'(a);
      b_r <= b;
    end else if (busy_r && (b_r != '0)) begin
      acc_r <= acc_r + pp[PW-1:0];
      ash_r <= ash_r << 8;
      b_r <= b_r >> 8;
    end
  end
endmodule

// ===== rtl/ahlg_root.sv =====
// Restoring square root / fraction divide unit, one result bit per cycle.
`timescale 1ns / 1ps
module ahlg_root #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ahlg_pkg::ru_req_t      req,
  input  logic [2*W-1:0]         x,
  input  logic [W-1:0]           n,
  input  logic [W-1:0]           d,
  output logic                   done,
  output logic [((W > F+2) ? W : F+2)-1:0] quo
);
  import ahlg_pkg::*;

  localparam int QW = (W > F + 2) ? W : F + 2;
  localparam int CNTW = $clog2(QW + 1);

  logic            busy_r;
  logic            is_root_r;
  logic            first_r;
  logic [CNTW-1:0] cnt_r;
  logic [W+1:0]    rem_r;
  logic [QW-1:0]   quo_r;
  logic [2*W-1:0]  x_r;
  logic [W-1:0]    d_r;
  logic [W+1:0]    rem_s;
  logic [W+1:0]    test;
  logic            take;

  // one compare-subtract step
  always_comb begin
    if (is_root_r) begin
      rem_s = {rem_r[W-1:0], x_r[2*W-1:2*W-2]};
      test = {quo_r[W-1:0], 2'b01};
    end else begin
      rem_s = first_r ? rem_r : {rem_r[W:0], 1'b0};
      test = {2'b00, d_r};
    end
    take = (rem_s >= test);
  end

  assign done = busy_r && (cnt_r == '0);
  assign quo = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_root_r <= req.is_root;
      first_r <= 1'b1;
      cnt_r <= req.is_root ? CNTW'(W) : CNTW'(F + 2);
      rem_r <= req.is_root ? '0 : {2'b00, n};
      quo_r <= '0;
      x_r <= x;
      d_r <= d;
    end else if (busy_r && (cnt_r != '0)) begin
      first_r <= 1'b0;
      cnt_r <= cnt_r - 1'b1;
      rem_r <= take ? (rem_s - test) : rem_s;
      quo_r <= {quo_r[QW-2:0], take};
      x_r <= x_r << 2;
    end
  end
endmodule

// ===== rtl/arrowhead_line_generator_3d.sv =====
// Top level: sequencer for the arrowhead line generator.
//
// Usage: an arrow word (tip mid_x/y/z and direction delta_x/y/z, signed,
// 1/256 mm) enters on in_ch when valid and ready are high. The block then
// drops ready and works the arrow alone: three squares, the length root,
// the in-plane root, four fraction divides, the barb offsets, and eight
// rounded products per barb, all on one shared multiplier (eight bits a
// cycle) and one root/divide unit (one bit a cycle). A direction along x
// skips the in-plane root and the divides. Each line word is held on
// out_ch until taken; a stall there simply holds the sequencer. Twelve
// words leave per arrow, last_line on the twelfth; a zero direction gives
// no word and ready returns after the root. cfg_ch is always ready: index
// 0 sets the color, index 1 the handle base; write only while idle. Reset
// restores color 7, handle base 0 and a zero line count.
`timescale 1ns / 1ps
module arrowhead_line_generator_3d #(
  parameter int COORD_WIDTH = 32,
  parameter int TRIG_FRAC_BITS = 16
) (
  input logic            clk,
  input logic            rst_n,
  ahlg_in_if.sink        in_ch,
  ahlg_out_if.source     out_ch,
  ahlg_cfg_if.sink       cfg_ch
);
  import ahlg_pkg::*;

  localparam int W = COORD_WIDTH;
  localparam int F = TRIG_FRAC_BITS;
  localparam int MB = (W > 32) ? W : 32;
  localparam int PW = W + MB;
  localparam int TW = F + 1;
  localparam int QW = (W > F + 2) ? W : F + 2;
  localparam int AW = W + 3;

  // trig term slots
  localparam int SX = 0;
  localparam int CX = 1;
  localparam int SZ = 2;
  localparam int CZ = 3;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQY  = 4'd1;
  localparam logic [3:0] S_SQZ  = 4'd2;
  localparam logic [3:0] S_SQX  = 4'd3;
  localparam logic [3:0] S_RTL  = 4'd4;
  localparam logic [3:0] S_RTR  = 4'd5;
  localparam logic [3:0] S_DSX  = 4'd6;
  localparam logic [3:0] S_DCX  = 4'd7;
  localparam logic [3:0] S_DSZ  = 4'd8;
  localparam logic [3:0] S_DCZ  = 4'd9;
  localparam logic [3:0] S_MA   = 4'd10;
  localparam logic [3:0] S_MB   = 4'd11;
  localparam logic [3:0] S_MC   = 4'd12;
  localparam logic [3:0] S_BARB = 4'd13;
  localparam logic [3:0] S_EMIT = 4'd14;

  localparam logic signed [AW-1:0] MAXV = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [AW-1:0] MINV = {4'b1111, {(W-1){1'b0}}};

  // control state
  logic [3:0]            state_r;
  logic                  pend_r;
  logic [2:0]            ms_r;
  logic [BARB_IDX_W-1:0] barb_r;
  logic [HANDLE_W-1:0]   line_cnt_r;
  logic [COLOR_W-1:0]    color_r;
  logic [HANDLE_W-1:0]   hbase_r;

  // payload
  logic signed [W-1:0] mid_r [3];
  logic [W-1:0]        dmag_r [3];
  logic                dneg_r [3];
  logic [PW-1:0]       sum_r;
  logic [PW-1:0]       syz_r;
  logic [W-1:0]        len_r;
  logic [W-1:0]        rad_r;
  logic [TW-1:0]       tmag_r [4];
  logic                tneg_r [4];
  logic [W-1:0]        a_r;
  logic [W-1:0]        b_r;
  logic [W-1:0]        c_r;
  logic signed [W+1:0] t_r;
  logic signed [AW-1:0] ex_r;
  logic signed [AW-1:0] ey_r;
  logic signed [AW-1:0] ez_r;

  // unit hookup
  logic          mul_start;
  logic [W-1:0]  mul_a;
  logic [MB-1:0] mul_b;
  logic [PW-1:0] mul_bias;
  logic          mul_done;
  logic [PW-1:0] mul_prod;
  ru_req_t       ru_req;
  logic [2*W-1:0] ru_x;
  logic [W-1:0]  ru_n;
  logic [W-1:0]  ru_d;
  logic          ru_done;
  logic [QW-1:0] ru_quo;
  logic          use_mul;
  logic          is_unit;
  logic          is_root;
  logic          unit_done;

  // barb operand selection
  logic [W-1:0]  h_val;
  logic [W:0]    h_sum;
  logic [W-1:0]  y0_mag;
  logic [W-1:0]  z0_mag;
  logic [W+1:0]  t_abs;
  logic          op_neg;
  logic [W-1:0]  op_mag;
  logic [1:0]    op_trig;
  logic          op_sub;
  logic [W-1:0]  res_mag;
  logic signed [AW-1:0] res_val;
  logic signed [AW-1:0] res_add;
  logic [F+2:0]  div_q1;
  logic [TW-1:0] div_mag;
  logic          in_acc;
  logic          out_acc;
  tcode_t        cy;
  tcode_t        cz;

  function automatic logic [W-1:0] pick_mag(tsel_t sel, logic [W-1:0] b, logic [W-1:0] c,
                                            logic [W-1:0] h);
    logic [W-1:0] v;
    unique case (sel)
      SEL_B:   v = b;
      SEL_C:   v = c;
      SEL_H:   v = h;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [W-1:0] sat(logic signed [AW-1:0] v);
    logic signed [AW-1:0] s;
    if (v > MAXV) s = MAXV;
    else if (v < MINV) s = MINV;
    else s = v;
    return s[W-1:0];
  endfunction

  ahlg_mul #(.AW(W), .BW(MB)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .bias(mul_bias), .done(mul_done), .prod(mul_prod)
  );

  ahlg_root #(.W(W), .F(F)) u_root (
    .clk(clk), .rst_n(rst_n), .req(ru_req), .x(ru_x), .n(ru_n), .d(ru_d),
    .done(ru_done), .quo(ru_quo)
  );

  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // barb template values
  assign h_sum = {1'b0, b_r} + 1'b1;
  assign h_val = h_sum[W:1];
  assign cy = TMPL_Y[barb_r];
  assign cz = TMPL_Z[barb_r];
  assign y0_mag = pick_mag(cy.sel, b_r, c_r, h_val);
  assign z0_mag = pick_mag(cz.sel, b_r, c_r, h_val);
  assign t_abs = t_r[W+1] ? (W+2)'(-t_r) : t_r;

  // product schedule for one barb
  always_comb begin
    unique case (ms_r)
      3'd0: begin op_mag = a_r; op_neg = 1'b1; op_trig = 2'(SZ); op_sub = 1'b0; end
      3'd1: begin op_mag = y0_mag; op_neg = cy.neg; op_trig = 2'(CZ); op_sub = 1'b0; end
      3'd2: begin op_mag = a_r; op_neg = 1'b1; op_trig = 2'(CZ); op_sub = 1'b0; end
      3'd3: begin op_mag = y0_mag; op_neg = cy.neg; op_trig = 2'(SZ); op_sub = 1'b1; end
      3'd4: begin op_mag = t_abs[W-1:0]; op_neg = t_r[W+1]; op_trig = 2'(CX); op_sub = 1'b0; end
      3'd5: begin op_mag = z0_mag; op_neg = cz.neg; op_trig = 2'(SX); op_sub = 1'b1; end
      3'd6: begin op_mag = t_abs[W-1:0]; op_neg = t_r[W+1]; op_trig = 2'(SX); op_sub = 1'b0; end
      default: begin
        op_mag = z0_mag; op_neg = cz.neg; op_trig = 2'(CX); op_sub = 1'b0;
      end
    endcase
  end

  // rounded product back to 1/256 mm, sign applied on the magnitude
  assign res_mag = mul_prod[F +: W];
  assign res_val = (op_neg ^ tneg_r[op_trig]) ? -AW'(res_mag) : AW'(res_mag);
  assign res_add = op_sub ? -res_val : res_val;

  // divide result rounded half up
  assign div_q1 = {1'b0, ru_quo[F+1:0]} + 1'b1;
  assign div_mag = div_q1[F+1:1];

  // unit operands per state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_bias = '0;
    ru_x = '0;
    ru_n = '0;
    ru_d = '0;
    use_mul = 1'b0;
    is_unit = 1'b1;
    is_root = 1'b0;
    unique case (state_r)
      S_SQY: begin
        use_mul = 1'b1; mul_a = dmag_r[1]; mul_b = MB'(dmag_r[1]);
      end
      S_SQZ: begin
        use_mul = 1'b1; mul_a = dmag_r[2]; mul_b = MB'(dmag_r[2]); mul_bias = sum_r;
      end
      S_SQX: begin
        use_mul = 1'b1; mul_a = dmag_r[0]; mul_b = MB'(dmag_r[0]); mul_bias = syz_r;
      end
      S_RTL: begin is_root = 1'b1; ru_x = sum_r[2*W-1:0]; end
      S_RTR: begin is_root = 1'b1; ru_x = syz_r[2*W-1:0]; end
      S_DSX: begin ru_n = dmag_r[2]; ru_d = rad_r; end
      S_DCX: begin ru_n = dmag_r[1]; ru_d = rad_r; end
      S_DSZ: begin ru_n = rad_r; ru_d = len_r; end
      S_DCZ: begin ru_n = dmag_r[0]; ru_d = len_r; end
      S_MA: begin
        use_mul = 1'b1; mul_a = len_r; mul_b = MB'(K_LONG_Q32);
        mul_bias = PW'(1) << 31;
      end
      S_MB: begin
        use_mul = 1'b1; mul_a = len_r; mul_b = MB'(K_SHORT_Q32);
        mul_bias = PW'(1) << 31;
      end
      S_MC: begin
        use_mul = 1'b1; mul_a = b_r; mul_b = MB'(K_COS30_Q16);
        mul_bias = PW'(1) << 15;
      end
      S_BARB: begin
        use_mul = 1'b1; mul_a = op_mag; mul_b = MB'(tmag_r[op_trig]);
        mul_bias = PW'(1) << (F - 1);
      end
      default: is_unit = 1'b0;
    endcase
  end

  assign mul_start = is_unit && use_mul && !pend_r;
  assign ru_req.start = is_unit && !use_mul && !pend_r;
  assign ru_req.is_root = is_root;
  assign unit_done = pend_r && (use_mul ? mul_done : ru_done);

  // sequencer and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r <= 1'b0;
      ms_r <= '0;
      barb_r <= '0;
      line_cnt_r <= '0;
      color_r <= COLOR_RESET;
      hbase_r <= '0;
    end else begin
      if (cfg_ch.valid) begin
        if (cfg_ch.index == REG_COLOR) color_r <= cfg_ch.data[COLOR_W-1:0];
        else if (cfg_ch.index == REG_HANDLE) hbase_r <= cfg_ch.data[HANDLE_W-1:0];
      end
      if (is_unit && !pend_r) begin
        pend_r <= 1'b1;
      end else if (unit_done) begin
        pend_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: if (in_acc) state_r <= S_SQY;
        S_SQY: if (unit_done) state_r <= S_SQZ;
        S_SQZ: if (unit_done) state_r <= S_SQX;
        S_SQX: if (unit_done) state_r <= S_RTL;
        S_RTL: begin
          if (unit_done) begin
            if (ru_quo[W-1:0] == '0) state_r <= S_IDLE;
            else if (dmag_r[1] == '0 && dmag_r[2] == '0) state_r <= S_MA;
            else state_r <= S_RTR;
          end
        end
        S_RTR: if (unit_done) state_r <= S_DSX;
        S_DSX: if (unit_done) state_r <= S_DCX;
        S_DCX: if (unit_done) state_r <= S_DSZ;
        S_DSZ: if (unit_done) state_r <= S_DCZ;
        S_DCZ: if (unit_done) state_r <= S_MA;
        S_MA: if (unit_done) state_r <= S_MB;
        S_MB: if (unit_done) state_r <= S_MC;
        S_MC: begin
          if (unit_done) begin
            state_r <= S_BARB;
            ms_r <= '0;
            barb_r <= '0;
          end
        end
        S_BARB: begin
          if (unit_done) begin
            ms_r <= ms_r + 1'b1;
            if (ms_r == 3'd7) state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            line_cnt_r <= line_cnt_r + 1'b1;
            if (barb_r == BARB_IDX_W'(NUM_BARBS - 1)) begin
              barb_r <= '0;
              state_r <= S_IDLE;
            end else begin
              barb_r <= barb_r + 1'b1;
              ms_r <= '0;
              state_r <= S_BARB;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath captures
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_r[0] <= in_ch.mid_x;
      mid_r[1] <= in_ch.mid_y;
      mid_r[2] <= in_ch.mid_z;
      dneg_r[0] <= in_ch.delta_x[W-1];
      dneg_r[1] <= in_ch.delta_y[W-1];
      dneg_r[2] <= in_ch.delta_z[W-1];
      dmag_r[0] <= in_ch.delta_x[W-1] ? W'(-in_ch.delta_x) : in_ch.delta_x;
      dmag_r[1] <= in_ch.delta_y[W-1] ? W'(-in_ch.delta_y) : in_ch.delta_y;
      dmag_r[2] <= in_ch.delta_z[W-1] ? W'(-in_ch.delta_z) : in_ch.delta_z;
    end
    if (unit_done) begin
      unique case (state_r)
        S_SQY: sum_r <= mul_prod;
        S_SQZ: syz_r <= mul_prod;
        S_SQX: sum_r <= mul_prod;
        S_RTL: begin
          len_r <= ru_quo[W-1:0];
          // direction along x: identity with the sign of dx
          tmag_r[SX] <= '0;
          tneg_r[SX] <= 1'b0;
          tmag_r[CX] <= TW'(1) << F;
          tneg_r[CX] <= 1'b0;
          tmag_r[SZ] <= '0;
          tneg_r[SZ] <= 1'b0;
          tmag_r[CZ] <= TW'(1) << F;
          tneg_r[CZ] <= dneg_r[0];
        end
        S_RTR: rad_r <= ru_quo[W-1:0];
        S_DSX: begin tmag_r[SX] <= div_mag; tneg_r[SX] <= dneg_r[2]; end
        S_DCX: begin tmag_r[CX] <= div_mag; tneg_r[CX] <= dneg_r[1]; end
        S_DSZ: begin tmag_r[SZ] <= div_mag; tneg_r[SZ] <= 1'b0; end
        S_DCZ: begin tmag_r[CZ] <= div_mag; tneg_r[CZ] <= dneg_r[0]; end
        S_MA: a_r <= mul_prod[32 +: W];
        S_MB: b_r <= mul_prod[32 +: W];
        S_MC: c_r <= mul_prod[16 +: W];
        S_BARB: begin
          unique case (ms_r[2:1])
            2'd0: t_r <= (W+2)'(AW'(t_r) + res_add);
            2'd1: ex_r <= ex_r + res_add;
            2'd2: ey_r <= ey_r + res_add;
            default: ez_r <= ez_r + res_add;
          endcase
        end
        default: ;
      endcase
    end
    // fresh accumulators at the start of every barb
    if ((state_r == S_MC && unit_done) ||
        (state_r == S_EMIT && out_acc)) begin
      t_r <= '0;
      ex_r <= AW'(mid_r[0]);
      ey_r <= AW'(mid_r[1]);
      ez_r <= AW'(mid_r[2]);
    end
  end

  // line word
  assign out_ch.valid = (state_r == S_EMIT);
  assign out_ch.start_x = mid_r[0];
  assign out_ch.start_y = mid_r[1];
  assign out_ch.start_z = mid_r[2];
  assign out_ch.end_x = sat(ex_r);
  assign out_ch.end_y = sat(ey_r);
  assign out_ch.end_z = sat(ez_r);
  assign out_ch.object_handle = hbase_r + line_cnt_r;
  assign out_ch.line_color = color_r;
  assign out_ch.last_line = (barb_r == BARB_IDX_W'(NUM_BARBS - 1));
endmodule

// ===== test/arrowhead_line_generator_3d_test.sv =====
// Self-checking testbench for the arrowhead line generator: random and directed arrows.
`timescale 1ns / 1ps
module arrowhead_line_generator_3d_test;
  import ahlg_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int LIMIT = 3000000;
  localparam int SETTLE = 900;

  typedef struct {
    logic signed [CW-1:0] mx, my, mz, dx, dy, dz;
  } arrow_t;

  typedef struct {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
    logic [HANDLE_W-1:0] handle;
    logic [COLOR_W-1:0] color;
    logic last;
  } line_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ahlg_in_if #(.CW(CW)) in_ch ();
  ahlg_out_if #(.CW(CW)) out_ch ();
  ahlg_cfg_if cfg_ch ();

  arrowhead_line_generator_3d #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor copy of block state
  logic [COLOR_W-1:0] color_q = COLOR_RESET;
  logic [31:0] handle_base_q = '0;
  logic [31:0] line_count_q = '0;

  arrow_t pending_arrows[$];
  line_t expected_lines[$];
  int errors = 0;
  int arrows_sent = 0;
  int lines_seen = 0;
  int cycles = 0;
  bit hold_done = 1'b0;

  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] isqrt(input logic [127:0] v);
    logic [127:0] rem, trial;
    logic [63:0] root;
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
      root = root << 1;
      trial = (128'(root) << 1) | 128'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  // round(n * 2^FB / d), n <= d
  function automatic longint ratio_round(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = '0;
    r = n;
    if (d == 0) return 0;
    if (r >= d) begin
      q = 1;
      r = r - d;
    end
    for (int k = 0; k <= FB; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        q = q | 64'd1;
        r = r - d;
      end
    end
    return longint'((q + 64'd1) >> 1);
  endfunction

  function automatic longint signed_ratio(input longint n, input logic [63:0] d);
    longint q;
    q = ratio_round(mag64(n), d);
    return n < 0 ? -q : q;
  endfunction

  // round(a*t / 2^sh), half away from zero
  function automatic longint scale_round(input longint a, input longint t, input int sh);
    logic [127:0] p;
    logic [63:0] m;
    bit neg;
    neg = (a < 0) != (t < 0);
    p = 128'(mag64(a)) * 128'(mag64(t));
    p = p + (128'd1 << (sh - 1));
    m = 64'(p >> sh) & ((64'd1 << 62) - 64'd1);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic signed [CW-1:0] clamp(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[CW-1:0];
  endfunction

  function automatic longint ring_pick(input tcode_t code, input longint b, input longint c,
                                       input longint h);
    longint v;
    case (code.sel)
      SEL_B: v = b;
      SEL_C: v = c;
      SEL_H: v = h;
      default: v = 0;
    endcase
    return code.neg ? -v : v;
  endfunction

  // Expected line words for one accepted arrow
  task automatic predict_arrow(input arrow_t w);
    longint mx, my, mz, dx, dy, dz, sx, cx, sz, cz, a, b, c, h, x0, y0, z0, t;
    longint ex, ey, ez;
    logic [127:0] acc;
    logic [63:0] len, rad;
    line_t ln;
    mx = w.mx; my = w.my; mz = w.mz; dx = w.dx; dy = w.dy; dz = w.dz;
    acc = 128'(mag64(dx)) * 128'(mag64(dx)) + 128'(mag64(dy)) * 128'(mag64(dy))
        + 128'(mag64(dz)) * 128'(mag64(dz));
    len = isqrt(acc);
    if (len == 0) return;
    if (dy == 0 && dz == 0) begin
      sx = 0;
      cx = 1 << FB;
      sz = 0;
      cz = dx < 0 ? -(1 << FB) : (1 << FB);
    end else begin
      rad = isqrt(128'(mag64(dy)) * 128'(mag64(dy)) + 128'(mag64(dz)) * 128'(mag64(dz)));
      sx = signed_ratio(dz, rad);
      cx = signed_ratio(dy, rad);
      sz = ratio_round(rad, len);
      cz = signed_ratio(dx, len);
    end
    a = scale_round(longint'(len), longint'(K_LONG_Q32), 32);
    b = scale_round(longint'(len), longint'(K_SHORT_Q32), 32);
    c = scale_round(b, longint'(K_COS30_Q16), 16);
    h = (b + 1) >>> 1;
    for (int k = 0; k < NUM_BARBS; k++) begin
      x0 = -a;
      y0 = ring_pick(TMPL_Y[k], b, c, h);
      z0 = ring_pick(TMPL_Z[k], b, c, h);
      t = scale_round(x0, sz, FB) + scale_round(y0, cz, FB);
      ex = mx + scale_round(x0, cz, FB) - scale_round(y0, sz, FB);
      ey = my + scale_round(t, cx, FB) - scale_round(z0, sx, FB);
      ez = mz + scale_round(t, sx, FB) + scale_round(z0, cx, FB);
      ln.sx = w.mx; ln.sy = w.my; ln.sz = w.mz;
      ln.ex = clamp(ex); ln.ey = clamp(ey); ln.ez = clamp(ez);
      ln.handle = handle_base_q + line_count_q;
      ln.color = color_q;
      ln.last = (k == NUM_BARBS - 1);
      line_count_q = line_count_q + 32'd1;
      expected_lines.push_back(ln);
    end
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
    return $urandom_range(0, 3);
  endfunction

  // Input driver
  logic drv_valid;
  int drv_gap = 0;
  arrow_t cur;
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      drv_valid = 1'b0;
    end else begin
      nv = drv_valid;
      if (drv_valid && in_ch.ready) begin
        predict_arrow(cur);
        arrows_sent++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (drv_gap > 0) drv_gap--;
        else if (pending_arrows.size() > 0) begin
          cur = pending_arrows.pop_front();
          in_ch.mid_x <= cur.mx; in_ch.mid_y <= cur.my; in_ch.mid_z <= cur.mz;
          in_ch.delta_x <= cur.dx; in_ch.delta_y <= cur.dy; in_ch.delta_z <= cur.dz;
          nv = 1'b1;
          drv_gap = rand_gap();
        end
      end
      drv_valid = nv;
      in_ch.valid <= nv;
    end
  end

  // Result monitor and receiver stalls
  int stall = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    line_t e;
    logic nr;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        lines_seen++;
        if (expected_lines.size() == 0) begin
          $display("%0t: unexpected line word, handle %h", $time, out_ch.object_handle);
          errors++;
        end else begin
          e = expected_lines.pop_front();
          if ({out_ch.start_x, out_ch.start_y, out_ch.start_z} != {e.sx, e.sy, e.sz}) begin
            $display("%0t: start exp %h %h %h got %h %h %h", $time, e.sx, e.sy, e.sz,
                     out_ch.start_x, out_ch.start_y, out_ch.start_z);
            errors++;
          end
          if (out_ch.end_x != e.ex) begin
            $display("%0t: end_x exp %h got %h", $time, e.ex, out_ch.end_x);
            errors++;
          end
          if (out_ch.end_y != e.ey) begin
            $display("%0t: end_y exp %h got %h", $time, e.ey, out_ch.end_y);
            errors++;
          end
          if (out_ch.end_z != e.ez) begin
            $display("%0t: end_z exp %h got %h", $time, e.ez, out_ch.end_z);
            errors++;
          end
          if (out_ch.object_handle != e.handle) begin
            $display("%0t: handle exp %h got %h", $time, e.handle, out_ch.object_handle);
            errors++;
          end
          if (out_ch.line_color != e.color) begin
            $display("%0t: color exp %0d got %0d", $time, e.color, out_ch.line_color);
            errors++;
          end
          if (out_ch.last_line != e.last) begin
            $display("%0t: last exp %b got %b", $time, e.last, out_ch.last_line);
            errors++;
          end
        end
      end
      // one long hold-off once the run is under way
      if (!hold_done && arrows_sent >= 60) begin
        hold_done = 1'b1;
        hold_left = 5000;
      end
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (stall > 0) begin
        stall--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
        stall = rand_gap();
      end
      out_ch.ready <= nr;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("arrowhead_line_generator_3d_test failed");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_COLOR) color_q = val[COLOR_W-1:0];
    else if (idx == REG_HANDLE) handle_base_q = val;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_arrows.size() == 0 && !drv_valid && expected_lines.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_arrow(input logic [31:0] mx, my, mz, dx, dy, dz);
    arrow_t w;
    w.mx = mx; w.my = my; w.mz = mz; w.dx = dx; w.dy = dy; w.dz = dz;
    pending_arrows.push_back(w);
  endtask

  function automatic logic [31:0] rand_delta(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // Random arrows: mostly real directions, some along x, a few zero
  task automatic add_random(input int n);
    int mode, kind;
    logic [31:0] mx, my, mz;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 19);
      mode = $urandom_range(0, 3);
      if ($urandom_range(0, 4) == 0) begin
        mx = $urandom_range(0, 1) ? 32'h7fffff00 + $urandom_range(0, 255) : $urandom();
        my = $urandom_range(0, 1) ? 32'h80000000 + $urandom_range(0, 255) : $urandom();
        mz = $urandom();
      end else begin
        mx = $urandom(); my = $urandom(); mz = $urandom();
      end
      if (kind == 0)
        add_arrow(mx, my, mz, 0, 0, 0);
      else if (kind < 3)
        add_arrow(mx, my, mz, rand_delta(mode), 0, 0);
      else
        add_arrow(mx, my, mz, rand_delta(mode), rand_delta($urandom_range(0, 3)),
                  rand_delta($urandom_range(0, 3)));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mid_x = '0; in_ch.mid_y = '0; in_ch.mid_z = '0;
    in_ch.delta_x = '0; in_ch.delta_y = '0; in_ch.delta_z = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed arrows at reset settings
    add_arrow(0, 0, 0, 0, 0, 0);
    add_arrow(100, 200, 300, 1, 0, 0);
    add_arrow(100, 200, 300, -1, 0, 0);
    add_arrow(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0);
    add_arrow(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0);
    add_arrow(0, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    add_arrow(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000);
    add_arrow(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1);
    add_arrow(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, -1);
    add_arrow(0, 0, 0, 0, 5120, 0);
    add_arrow(0, 0, 0, 0, 0, -5120);
    add_arrow(1000, -1000, 0, 0, 0, 0);
    add_arrow(-5, 7, 9, 3, -4, 12);
    add_arrow(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              32'hffffffff);
    add_arrow(32'h55555555, 32'haaaaaaaa, 32'h33333333, 32'haaaaaaaa, 32'h55555555,
              32'hcccccccc);
    add_arrow(0, 0, 0, 0, 1, 1);
    wait_idle();

    // Phase with handle wrap and color 256 (top bit of the color set)
    cfg_write(REG_COLOR, 256);
    cfg_write(REG_HANDLE, 32'hfffffff0);
    cfg_write(4'd5, 32'h12345678);
    add_arrow(0, 0, 0, 256, 256, 256);
    add_random(110);
    wait_idle();

    // Color zero, full-width color write, random handle
    cfg_write(REG_COLOR, 0);
    cfg_write(REG_HANDLE, $urandom());
    add_random(90);
    wait_idle();

    cfg_write(REG_COLOR, 32'hffffffff);
    cfg_write(REG_HANDLE, 32'hffffffff);
    add_random(80);
    wait_idle();

    cfg_write(REG_COLOR, $urandom_range(0, 256));
    cfg_write(REG_HANDLE, 0);
    add_random(70);
    wait_idle();

    $display("Covered %0d arrows and %0d line words over five register settings,",
             arrows_sent, lines_seen);
    $display("including zero and axis directions, saturation, handle wrap and a long stall.");
    if (errors == 0 && expected_lines.size() == 0) begin
      $display("arrowhead_line_generator_3d_test passed");
    end else begin
      $display("arrowhead_line_generator_3d_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ahlg_pkg.sv
rtl/ahlg_in_if.sv
rtl/ahlg_out_if.sv
rtl/ahlg_cfg_if.sv
rtl/ahlg_mul.sv
rtl/ahlg_root.sv
rtl/arrowhead_line_generator_3d.sv
test/arrowhead_line_generator_3d_test.sv
